// ===== hdl/keyframe_range_interpolator_macros.svh =====
// assertion macros for the keyframe range interpolator
// no dependencies; included by the top level
`ifndef KEYFRAME_RANGE_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_RANGE_INTERPOLATOR_MACROS_SVH

// same-cycle implication under asynchronous reset
`define KRI_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("kri assertion failed");

// next-cycle implication under asynchronous reset
`define KRI_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("kri assertion failed");

`endif

// ===== hdl/kri_pkg.sv =====
// types and codes for the keyframe range interpolator
// no dependencies
`timescale 1ns / 1ps

package kri_pkg;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_PAIR      = 3'd4;

	typedef struct packed {
		logic        mode;
		logic [31:0] key_time;
		logic [31:0] window_end;
		logic [31:0] head_x;
		logic [31:0] head_y;
		logic [31:0] head_z;
		logic [31:0] tail_x;
		logic [31:0] tail_y;
		logic [31:0] tail_z;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_head_x;
		logic [31:0] out_head_y;
		logic [31:0] out_head_z;
		logic [31:0] out_tail_x;
		logic [31:0] out_tail_y;
		logic [31:0] out_tail_z;
		logic        interpolated;
		logic        last;
	} rsp_t;

	// one table entry: key time and six coordinates
	typedef struct packed {
		logic [31:0]      ktime;
		logic [5:0][31:0] crd;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_INS_DEC, S_SH_RD, S_SH_WR, S_INS_WR,
		S_Q_DEC, S_RNG_RD, S_RNG_CHK, S_DIV_SET, S_DIV, S_MUL, S_ADD, S_EMIT
	} state_t;

endpackage

// ===== hdl/keyframe_range_interpolator.sv =====
// keyframe range interpolator top level: sorted keyframe table and window query
// depends on kri_pkg and keyframe_range_interpolator_macros.svh
`timescale 1ns / 1ps
`include "keyframe_range_interpolator_macros.svh"

// Holds up to TABLE_DEPTH keyframes sorted by time in one synchronous
// memory with one read port and one write port. An insert searches from
// the bottom, then, unless the key is a duplicate or the table is full,
// moves the entries above its place up by one and writes the new one. A
// query walks the table and emits one word per key in the window; each
// blended word runs a 16-step fraction divider, then six shared multiply
// and add passes. Only one word is in progress at a time; the output
// register lets the next command enter while the last word waits.
// No clearing pass: entries above the fill count are never used.
module keyframe_range_interpolator #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  kri_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output kri_pkg::rsp_t rsp
);
	import kri_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	// keyframe table
	entry_t mem [TABLE_DEPTH];
	entry_t rd_data_q;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic wr_en;
	entry_t wr_data;

	state_t state_q, state_d, after_q;
	cmd_t cmd_q;
	logic [31:0] te_q, blend_tm_q;
	logic [CNT_W-1:0] idx_q, pos_q, count_q;
	logic found_q, dup_q;
	entry_t ent_a_q, ent_b_q;        // ent_a: previous key, ent_b: next key
	rsp_t word_q, rsp_q;
	logic rsp_valid_q;

	// fraction divider and shared multiplier
	logic [31:0] rem_q, den_q;
	logic [15:0] quo_q;
	logic [3:0] bit_q;
	logic [2:0] crd_q;
	logic signed [49:0] prod_q;

	logic slot_free, hit, at_end;
	logic [32:0] rem2;
	logic signed [32:0] diff;
	logic [31:0] crd_res;

	function automatic rsp_t mk_word(logic [2:0] st, entry_t e, logic use_e, logic lst);
		rsp_t w;
		w.status = st;
		w.out_head_x = use_e ? e.crd[0] : 32'd0;
		w.out_head_y = use_e ? e.crd[1] : 32'd0;
		w.out_head_z = use_e ? e.crd[2] : 32'd0;
		w.out_tail_x = use_e ? e.crd[3] : 32'd0;
		w.out_tail_y = use_e ? e.crd[4] : 32'd0;
		w.out_tail_z = use_e ? e.crd[5] : 32'd0;
		w.interpolated = 1'b0;
		w.last = lst;
		return w;
	endfunction

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign at_end = (idx_q == count_q);
	// insert stops at the first key not below it, query at the first key above
	assign hit = (cmd_q.mode == MODE_QUERY) ? (rd_data_q.ktime > cmd_q.key_time)
		: (rd_data_q.ktime >= cmd_q.key_time);
	assign rem2 = {rem_q, 1'b0};
	assign diff = $signed({ent_b_q.crd[crd_q][31], ent_b_q.crd[crd_q]})
		- $signed({ent_a_q.crd[crd_q][31], ent_a_q.crd[crd_q]});
	// floor of product over 2^16, then offset from the lower key
	assign crd_res = ent_a_q.crd[crd_q] + prod_q[47:16];

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// memory ports
	always_comb begin
		rd_addr = idx_q[IDX_W-1:0];
		if (state_q == S_SH_RD) begin
			rd_addr = IDX_W'(idx_q - 1'b1);
		end
		wr_en = (state_q == S_SH_WR) || (state_q == S_INS_WR);
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = rd_data_q;
		if (state_q == S_INS_WR) begin
			wr_data.ktime = cmd_q.key_time;
			wr_data.crd = {cmd_q.tail_z, cmd_q.tail_y, cmd_q.tail_x,
				cmd_q.head_z, cmd_q.head_y, cmd_q.head_x};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.mode == MODE_QUERY && count_q == '0) state_d = S_EMIT;
					else state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (at_end) state_d = (cmd_q.mode == MODE_QUERY) ? S_Q_DEC : S_INS_DEC;
				else state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				if (hit) state_d = (cmd_q.mode == MODE_QUERY) ? S_Q_DEC : S_INS_DEC;
				else state_d = S_SCAN_RD;
			end
			S_INS_DEC: begin
				if (found_q && dup_q) state_d = S_EMIT;
				else if (count_q >= DEPTH_C) state_d = S_EMIT;
				else if (count_q > idx_q) state_d = S_SH_RD;
				else state_d = S_INS_WR;
			end
			S_SH_RD: state_d = S_SH_WR;
			S_SH_WR: state_d = (idx_q - 1'b1 > pos_q) ? S_SH_RD : S_INS_WR;
			S_INS_WR: state_d = S_EMIT;
			S_Q_DEC: begin
				if (!found_q || idx_q == '0) state_d = S_EMIT;
				else state_d = S_DIV_SET;
			end
			S_RNG_RD: state_d = at_end ? S_IDLE : S_RNG_CHK;
			S_RNG_CHK: state_d = (rd_data_q.ktime > te_q) ? S_DIV_SET : S_EMIT;
			S_DIV_SET: state_d = S_DIV;
			S_DIV: state_d = (bit_q == '0) ? S_MUL : S_DIV;
			S_MUL: state_d = S_ADD;
			S_ADD: state_d = (crd_q == 3'd5) ? S_EMIT : S_MUL;
			S_EMIT: state_d = slot_free ? after_q : S_EMIT;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INS_WR) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_EMIT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= cmd;
				te_q <= (cmd.window_end < cmd.key_time) ? cmd.key_time : cmd.window_end;
				idx_q <= '0;
				found_q <= 1'b0;
				word_q <= mk_word(ST_EMPTY, ent_a_q, 1'b0, 1'b1);
				after_q <= S_IDLE;
			end
			S_SCAN_CHK: begin
				if (hit) begin
					found_q <= 1'b1;
					dup_q <= (rd_data_q.ktime == cmd_q.key_time);
					ent_b_q <= rd_data_q;
				end else begin
					ent_a_q <= rd_data_q;
					idx_q <= idx_q + 1'b1;
				end
			end
			S_INS_DEC: begin
				pos_q <= idx_q;
				idx_q <= count_q;
				after_q <= S_IDLE;
				if (found_q && dup_q) word_q <= mk_word(ST_DUPLICATE, ent_a_q, 1'b0, 1'b1);
				else if (count_q >= DEPTH_C) word_q <= mk_word(ST_FULL, ent_a_q, 1'b0, 1'b1);
				else word_q <= mk_word(ST_INSERTED, ent_a_q, 1'b0, 1'b1);
			end
			S_SH_WR: idx_q <= idx_q - 1'b1;
			S_Q_DEC: begin
				if (!found_q) begin
					// start at or past the last key
					word_q <= mk_word(ST_PAIR, ent_a_q, 1'b1, 1'b1);
					after_q <= S_IDLE;
				end else if (idx_q == '0) begin
					// start before the first key
					word_q <= mk_word(ST_PAIR, ent_b_q, 1'b1,
						(count_q == CNT_W'(1)) || (ent_b_q.ktime > te_q));
					after_q <= ((count_q == CNT_W'(1)) || (ent_b_q.ktime > te_q))
						? S_IDLE : S_RNG_RD;
					ent_a_q <= ent_b_q;
					idx_q <= CNT_W'(1);
				end else begin
					word_q <= mk_word(ST_PAIR, ent_a_q, 1'b0, 1'b0);
					blend_tm_q <= cmd_q.key_time;
					after_q <= S_RNG_RD;
				end
			end
			S_RNG_CHK: begin
				if (rd_data_q.ktime > te_q) begin
					ent_b_q <= rd_data_q;
					blend_tm_q <= te_q;
					word_q <= mk_word(ST_PAIR, ent_a_q, 1'b0, 1'b1);
					after_q <= S_IDLE;
				end else begin
					word_q <= mk_word(ST_PAIR, rd_data_q, 1'b1, (idx_q + 1'b1) == count_q);
					after_q <= ((idx_q + 1'b1) == count_q) ? S_IDLE : S_RNG_RD;
					ent_a_q <= rd_data_q;
					idx_q <= idx_q + 1'b1;
				end
			end
			S_DIV_SET: begin
				rem_q <= blend_tm_q - ent_a_q.ktime;
				den_q <= ent_b_q.ktime - ent_a_q.ktime;
				bit_q <= 4'd15;
				crd_q <= '0;
				word_q.interpolated <= 1'b1;
			end
			S_DIV: begin
				if (rem2 >= {1'b0, den_q}) begin
					rem_q <= 32'(rem2 - {1'b0, den_q});
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= rem2[31:0];
					quo_q <= {quo_q[14:0], 1'b0};
				end
				bit_q <= bit_q - 1'b1;
			end
			S_MUL: prod_q <= diff * $signed({1'b0, quo_q});
			S_ADD: begin
				case (crd_q)
					3'd0: word_q.out_head_x <= crd_res;
					3'd1: word_q.out_head_y <= crd_res;
					3'd2: word_q.out_head_z <= crd_res;
					3'd3: word_q.out_tail_x <= crd_res;
					3'd4: word_q.out_tail_y <= crd_res;
					default: word_q.out_tail_z <= crd_res;
				endcase
				crd_q <= crd_q + 1'b1;
			end
			S_EMIT: begin
				if (slot_free) rsp_q <= word_q;
			end
			default: begin
			end
		endcase
	end

	// table never overfills
	`KRI_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= DEPTH_C)
	// a new keyframe write grows the table by exactly one
	`KRI_ASSERT_NEXT(a_count_step, clk, arst_n, state_q == S_INS_WR,
		count_q == $past(count_q) + 1'b1)
	// restoring divider keeps the partial remainder below the key gap
	`KRI_ASSERT_IMPL(a_div_rem, clk, arst_n, state_q == S_DIV, rem_q < den_q)

endmodule

// ===== test/keyframe_range_interpolator_checker.sv =====
// response checker for the keyframe range interpolator
// depends on kri_pkg; watches both word channels and predicts every response word
`timescale 1ns / 1ps

module keyframe_range_interpolator_checker #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  kri_pkg::cmd_t cmd,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  kri_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending
);
	import kri_pkg::*;

	logic [31:0] key_tab [TABLE_DEPTH];
	logic [31:0] crd_tab [TABLE_DEPTH][6];
	int          fill;
	rsp_t        expected_words [$];
	int          mismatches;

	assign pending    = expected_words.size();
	assign fail_count = mismatches;

	function automatic rsp_t pack_coords(logic [31:0] c [6], logic interp);
		rsp_t w;
		w              = '0;
		w.status       = ST_PAIR;
		w.out_head_x   = c[0];
		w.out_head_y   = c[1];
		w.out_head_z   = c[2];
		w.out_tail_x   = c[3];
		w.out_tail_y   = c[4];
		w.out_tail_z   = c[5];
		w.interpolated = interp;
		return w;
	endfunction

	function automatic rsp_t key_pair(int idx);
		return pack_coords(crd_tab[idx], 1'b0);
	endfunction

	// linear blend between entries lo and lo+1 at time tm
	function automatic rsp_t blended_pair(int lo, logic [31:0] tm);
		longint unsigned num, den;
		longint          diff, prod;
		logic [15:0]     frac;
		logic [31:0]     c [6];
		num  = longint'({32'd0, tm - key_tab[lo]}) << 16;
		den  = longint'({32'd0, key_tab[lo + 1] - key_tab[lo]});
		frac = 16'(num / den);
		for (int j = 0; j < 6; j++) begin
			diff = longint'($signed(crd_tab[lo + 1][j])) - longint'($signed(crd_tab[lo][j]));
			prod = diff * longint'({48'd0, frac});
			c[j] = 32'(longint'($signed(crd_tab[lo][j])) + (prod >>> 16));
		end
		return pack_coords(c, 1'b1);
	endfunction

	// number of keys at or below tm
	function automatic int keys_up_to(logic [31:0] tm);
		int i;
		i = 0;
		while (i < fill && key_tab[i] <= tm)
			i++;
		return i;
	endfunction

	task automatic predict(cmd_t c);
		rsp_t        words [$];
		rsp_t        w;
		int          p, s, e, from;
		logic [31:0] te;
		w = '0;
		if (c.mode == MODE_INSERT) begin
			p = 0;
			while (p < fill && key_tab[p] < c.key_time)
				p++;
			if (p < fill && key_tab[p] == c.key_time) begin
				w.status = ST_DUPLICATE;
			end else if (fill >= TABLE_DEPTH) begin
				w.status = ST_FULL;
			end else begin
				for (int i = fill; i > p; i--) begin
					key_tab[i] = key_tab[i - 1];
					crd_tab[i] = crd_tab[i - 1];
				end
				key_tab[p]    = c.key_time;
				crd_tab[p][0] = c.head_x;
				crd_tab[p][1] = c.head_y;
				crd_tab[p][2] = c.head_z;
				crd_tab[p][3] = c.tail_x;
				crd_tab[p][4] = c.tail_y;
				crd_tab[p][5] = c.tail_z;
				fill++;
				w.status = ST_INSERTED;
			end
			words = {words, w};
		end else if (fill == 0) begin
			w.status = ST_EMPTY;
			words = {words, w};
		end else begin
			te = (c.window_end < c.key_time) ? c.key_time : c.window_end;
			s  = keys_up_to(c.key_time);
			if (s == fill) begin
				words = {words, key_pair(s - 1)};
			end else begin
				if (s == 0) begin
					words = {words, key_pair(0)};
					from = 1;
				end else begin
					words = {words, blended_pair(s - 1, c.key_time)};
					from = s;
				end
				e = keys_up_to(te);
				for (int i = from; i < e; i++)
					words = {words, key_pair(i)};
				if (e != 0 && e != fill)
					words = {words, blended_pair(e - 1, te)};
			end
		end
		words[words.size() - 1].last = 1'b1;
		foreach (words[k])
			expected_words = {expected_words, words[k]};
	endtask

	task automatic report(string what, rsp_t exp, rsp_t act);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %h, got %h", $realtime, what, exp, act);
	endtask

	task automatic compare(rsp_t act);
		rsp_t exp;
		if (expected_words.size() == 0) begin
			report("unexpected word", '0, act);
			return;
		end
		exp = expected_words.pop_front();
		if (act.status !== exp.status) report("status", exp, act);
		if (act.out_head_x !== exp.out_head_x) report("out_head_x", exp, act);
		if (act.out_head_y !== exp.out_head_y) report("out_head_y", exp, act);
		if (act.out_head_z !== exp.out_head_z) report("out_head_z", exp, act);
		if (act.out_tail_x !== exp.out_tail_x) report("out_tail_x", exp, act);
		if (act.out_tail_y !== exp.out_tail_y) report("out_tail_y", exp, act);
		if (act.out_tail_z !== exp.out_tail_z) report("out_tail_z", exp, act);
		if (act.interpolated !== exp.interpolated) report("interpolated", exp, act);
		if (act.last !== exp.last) report("last", exp, act);
	endtask

	initial begin
		fill       = 0;
		mismatches = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				predict(cmd);
			if (rsp_valid && !rsp_stall)
				compare(rsp);
		end
	end

endmodule

// ===== test/testbench.sv =====
// top of the keyframe range interpolator testbench: clock, reset, stimulus, verdict
// depends on kri_pkg, keyframe_range_interpolator and keyframe_range_interpolator_checker
`timescale 1ns / 1ps

module testbench;
	import kri_pkg::*;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	int   fail_count;
	int   pending;
	// when set, neither side idles
	logic no_idle   = 1'b0;
	int   stall_left = 0;

	always #5 clk = ~clk;

	keyframe_range_interpolator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	keyframe_range_interpolator_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver stall pattern, same shape as the sender gaps
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= 1'b1;
		end else begin
			stall_left <= gap_len();
			rsp_stall  <= 1'b0;
		end
	end

	// hand one word to the block, hold it until taken, then idle a while
	task automatic issue(cmd_t c);
		int g;
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		g = gap_len();
		if (g > 0) begin
			cmd_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// coordinates: random, with the extremes showing up often
	function automatic logic [31:0] coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'h8000_0000;
		if (r == 1) return 32'h7fff_ffff;
		return $urandom;
	endfunction

	// times cluster on a small grid so keys collide and windows hit keys
	function automatic logic [31:0] pick_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) return $urandom;
		if (r < 15) return 32'hffff_ffff - $urandom_range(0, 3);
		return ($urandom_range(0, 63) << 14) + $urandom_range(0, 3);
	endfunction

	function automatic cmd_t insert_word(logic [31:0] t);
		cmd_t c;
		c.mode       = MODE_INSERT;
		c.key_time   = t;
		c.window_end = $urandom;
		c.head_x     = coord();
		c.head_y     = coord();
		c.head_z     = coord();
		c.tail_x     = coord();
		c.tail_y     = coord();
		c.tail_z     = coord();
		return c;
	endfunction

	function automatic cmd_t query_word(logic [31:0] ts, logic [31:0] te);
		cmd_t c;
		c            = insert_word(ts);
		c.mode       = MODE_QUERY;
		c.window_end = te;
		return c;
	endfunction

	initial begin
		cmd_t        c;
		logic [31:0] ts;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, ordered keys, duplicate, every window shape
		issue(query_word(32'h0005_0000, 32'h0009_0000));
		c = insert_word(32'h0014_0000);
		c.head_x = 32'h7fff_ffff; c.tail_x = 32'h8000_0000;
		issue(c);
		c = insert_word(32'h000a_0000);
		c.head_x = 32'h8000_0000; c.tail_x = 32'h7fff_ffff;
		issue(c);
		issue(insert_word(32'h001e_0000));
		issue(insert_word(32'h0014_0000));
		issue(query_word(32'h0005_0000, 32'h0019_0000));
		issue(query_word(32'h0000_0000, 32'h0001_0000));
		issue(query_word(32'h000c_8000, 32'h0001_0000));
		issue(query_word(32'h0028_0000, 32'h0030_0000));
		issue(query_word(32'h0014_0000, 32'h001e_0000));
		issue(query_word(32'h000c_8000, 32'h001b_4ccd));
		issue(query_word(32'h0014_0001, 32'h0014_ffff));
		c = insert_word(32'h0000_0000);
		c.head_y = 32'h8000_0000; c.tail_z = 32'h8000_0000;
		issue(c);
		c = insert_word(32'hffff_ffff);
		c.head_y = 32'h7fff_ffff; c.tail_z = 32'h7fff_ffff;
		issue(c);
		issue(query_word(32'h0000_0000, 32'hffff_ffff));
		issue(query_word(32'hffff_ffff, 32'h0000_0000));
		issue(query_word(32'h0020_0000, 32'hffff_fffe));

		// random: inserts fill the table and then hit the full case
		for (int n = 0; n < 155; n++) begin
			no_idle <= (n >= 40 && n < 60);
			if (n == 90) begin
				// let the block drain before going on
				cmd_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			ts = pick_time();
			if ($urandom_range(0, 99) < 50)
				issue(insert_word(ts));
			else if ($urandom_range(0, 9) < 2)
				issue(query_word(ts, $urandom));
			else
				issue(query_word(ts, ts + ($urandom_range(0, 40) << 13)));
		end
		cmd_valid <= 1'b0;
		no_idle   <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("keyframe_range_interpolator verification clean");
		else
			$display("keyframe_range_interpolator verification failed");
		$finish;
	end

	// hard limit on the run
	initial begin
		#30ms;
		$display("keyframe_range_interpolator verification failed");
		$finish;
	end

endmodule
